// ===== rtl/core/bsed_pkg.sv =====
// package for the binary string edit distance block
// sizes, control structs and controller state codes; no dependencies
package bsed_pkg;

  localparam int STRING_LEN  = 32;
  localparam int COUNT_WIDTH = 6;
  localparam int FIELD_W     = 32;
  localparam int DIST_W      = 6;
  localparam int EXT_W       = (STRING_LEN > FIELD_W) ? STRING_LEN : FIELD_W;
  localparam int CELL_W      = $clog2(STRING_LEN + 1);
  localparam int STEP_W      = $clog2(2 * STRING_LEN + 1);
  localparam int LAST_STEP   = 2 * STRING_LEN;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [DIST_W-1:0]  dist_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_e;

endpackage

// ===== rtl/core/bsed_intf.sv =====
// valid/ready channel interfaces for the input pair and the distance result
// depends on bsed_pkg
interface bsed_in_if;
  import bsed_pkg::*;
  logic   valid;
  logic   ready;
  field_t first_string;
  field_t second_string;
  modport source (output valid, output first_string, output second_string, input ready);
  modport sink (input valid, input first_string, input second_string, output ready);
endinterface

interface bsed_out_if;
  import bsed_pkg::*;
  logic  valid;
  logic  ready;
  dist_t distance;
  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface

// ===== rtl/core/bsed_datapath.sv =====
// anti-diagonal wavefront datapath: one cell per table row, two diagonals kept
// depends on bsed_pkg
module bsed_datapath
  import bsed_pkg::*;
(
  input  logic             clk_i,
  input  bsed_pkg::field_t a_i,
  input  bsed_pkg::field_t b_i,
  input  bsed_pkg::cmd_t   cmd_i,
  output bsed_pkg::sts_t   sts_o,
  output bsed_pkg::dist_t  dist_o
);

  logic [EXT_W-1:0]      a_q;
  logic [FIELD_W-1:0]    bsrc_q;
  logic [STRING_LEN-1:0] bwin_q;
  logic [STEP_W-1:0]     k_q;
  logic [CELL_W-1:0]     cur_q [STRING_LEN+1];
  logic [CELL_W-1:0]     prv_q [STRING_LEN+1];
  logic [CELL_W-1:0]     nxt   [STRING_LEN+1];
  logic [CELL_W-1:0]     up    [STRING_LEN+1];
  logic [CELL_W-1:0]     lf    [STRING_LEN+1];
  logic [CELL_W-1:0]     dg    [STRING_LEN+1];
  logic [CELL_W-1:0]     m1    [STRING_LEN+1];
  logic [COUNT_WIDTH-1:0] cnt;
  dist_t                 dist_q;

  // cell i handles table row i; b char for cell i arrives through bwin
  always_comb begin
    nxt[0] = CELL_W'(k_q);
    up[0]  = '0;
    lf[0]  = '0;
    dg[0]  = '0;
    m1[0]  = '0;
    for (int i = 1; i <= STRING_LEN; i++) begin
      up[i] = cur_q[i-1] + CELL_W'(1);
      lf[i] = cur_q[i] + CELL_W'(1);
      dg[i] = prv_q[i-1] + CELL_W'(a_q[i-1] ^ bwin_q[i-1]);
      m1[i] = (lf[i] < up[i]) ? lf[i] : up[i];
      if (STEP_W'(i) == k_q) begin
        nxt[i] = CELL_W'(i);
      end else begin
        nxt[i] = (dg[i] < m1[i]) ? dg[i] : m1[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= EXT_W'(a_i);
      bsrc_q <= b_i;
      bwin_q <= '0;
      k_q    <= STEP_W'(1);
      for (int i = 0; i <= STRING_LEN; i++) begin
        cur_q[i] <= '0;
        prv_q[i] <= '0;
      end
    end else if (cmd_i.step) begin
      bsrc_q <= bsrc_q >> 1;
      bwin_q <= STRING_LEN'({bwin_q, bsrc_q[0]});
      k_q    <= k_q + STEP_W'(1);
      for (int i = 0; i <= STRING_LEN; i++) begin
        cur_q[i] <= nxt[i];
        prv_q[i] <= cur_q[i];
      end
    end
  end

  assign cnt = COUNT_WIDTH'(cur_q[STRING_LEN]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      dist_q <= DIST_W'(cnt);
    end
  end

  assign sts_o.last = (k_q == STEP_W'(LAST_STEP));
  assign dist_o     = dist_q;

  a_step_range: assert property (@(posedge clk_i)
    cmd_i.step |-> (k_q >= STEP_W'(1) && k_q <= STEP_W'(LAST_STEP)))
    else $error("step count out of range");

  a_load_start: assert property (@(posedge clk_i)
    cmd_i.load |=> (k_q == STEP_W'(1)))
    else $error("load did not restart the sweep");

endmodule

// ===== rtl/core/bsed_ctrl.sv =====
// controller state machine: accept, sweep, hand result to the output register
// depends on bsed_pkg
module bsed_ctrl
  import bsed_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  bsed_pkg::sts_t sts_i,
  output bsed_pkg::cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && sts_i.last) |=> (state_q == ST_FIN))
    else $error("sweep did not finish after last step");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("emitted beat not presented");

endmodule

// ===== rtl/core/binary_string_edit_distance.sv =====
// top level of the binary string edit distance block
// depends on bsed_pkg, bsed_intf, bsed_ctrl, bsed_datapath
//
//   channel  dir  payload                        handshake
//   in_i     in   first_string, second_string    valid / ready
//   out_o    out  distance                       valid / ready
//
// one pair runs from accept to result through the anti-diagonal sweep,
// which computes one table diagonal per cycle
// a new pair is accepted while the previous result waits in the output register
// a stalled output holds only the final hand-off; reset clears control state only
module binary_string_edit_distance
  import bsed_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  bsed_in_if.sink    in_i,
  bsed_out_if.source out_o
);

  cmd_t  cmd;
  sts_t  sts;
  dist_t result_dist;

  bsed_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bsed_datapath u_datapath (
    .clk_i  (clk_i),
    .a_i    (in_i.first_string),
    .b_i    (in_i.second_string),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .dist_o (result_dist)
  );

  assign out_o.distance = result_dist;

endmodule
